@@ hdl/sorted_delay_release_queue_macros.svh @@
// Assertion macros for the checker of the sorted delay release queue.
// Each macro expects signals named clock and reset in the scope where it is used.
`ifndef SORTED_DELAY_RELEASE_QUEUE_MACROS_SVH
`define SORTED_DELAY_RELEASE_QUEUE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SDRQ_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SDRQ_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ hdl/sdrq_pkg.sv @@
package sdrq_pkg;

   // Field widths of the payload.
   localparam int FUNC_W     = 2;
   localparam int ID_W       = 6;
   localparam int TICK_W     = 32;
   localparam int ID_SLOTS   = 64;
   localparam int REQ_DATA_W = 40;
   localparam int RSP_DATA_W = 40;

   // Request kinds carried in req_tuser.
   typedef enum logic [FUNC_W-1:0] {
      FUNC_TICK  = 2'd0,
      FUNC_QUERY = 2'd1,
      FUNC_REL   = 2'd2,
      FUNC_ABS   = 2'd3
   } func_type;

   // Result kinds carried in rsp_tuser.
   typedef enum logic [1:0] {
      KIND_RELEASE = 2'd0,
      KIND_TIME    = 2'd1,
      KIND_REJECT  = 2'd2
   } kind_type;

   // Operation broadcast to every cell of the chain.
   typedef enum logic [1:0] {
      OP_HOLD   = 2'd0,
      OP_INSERT = 2'd1,
      OP_POP    = 2'd2
   } op_type;

   // One slot of the sorted list.
   typedef struct packed {
      logic              valid;
      logic [TICK_W-1:0] deadline;
      logic [ID_W-1:0]   task_id;
   } entry_type;

   // Command bus from the controller to the cells.
   typedef struct packed {
      op_type            op;
      logic [TICK_W-1:0] deadline;
      logic [ID_W-1:0]   task_id;
   } cell_cmd_type;

endpackage

@@ hdl/sorted_delay_release_queue.sv @@
// Sorted delay release queue.
// Requests arrive on req_*: req_tuser selects tick, time query, relative delay
// or absolute delay; req_tdata carries the task id and the tick value.
// Results leave on rsp_*: rsp_tuser gives release, time reply or rejection,
// rsp_tdata the task id and the current count, rsp_tlast marks the final
// result caused by one request.
// A time query or a delay needs no drain, so one such request per cycle is
// accepted while the result register is free or being drained. A time reply
// or rejection appears in the cycle after the transfer.
// A tick advances the count and then drains the tasks that are due; the
// releases are read from the head of the sorted cell chain, one per cycle
// while the result register is free or being drained, and no request is
// accepted meanwhile. An insert shifts the chain, each cell comparing its own
// deadline against the broadcast one.
// When the receiver stalls, the result register holds its value and no new
// request is taken until it empties. Reset clears the count, the waiting set
// and the valid bits of all cells.
module sorted_delay_release_queue
   import sdrq_pkg::*;
#(
   parameter int TASKS = 64
)(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,  // task_id [5:0], tick_value [37:6]
   input  logic [FUNC_W-1:0]     req_tuser,  // func [1:0]
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,  // released_id [5:0], time_now [37:6]
   output logic [1:0]            rsp_tuser,  // kind [1:0]
   output logic                  rsp_tlast
);

   typedef enum logic [1:0] {
      ST_IDLE  = 2'b01,
      ST_DRAIN = 2'b10
   } state_type;

   state_type           state_ff, state_in;
   logic [TICK_W-1:0]   count_ff, count_in;
   logic [ID_SLOTS-1:0] waiting_ff, waiting_in;
   logic                rsp_valid_ff, rsp_valid_in;
   kind_type            rsp_kind_ff, rsp_kind_in;
   logic [ID_W-1:0]     rsp_id_ff, rsp_id_in;
   logic [TICK_W-1:0]   rsp_time_ff, rsp_time_in;
   logic                rsp_last_ff, rsp_last_in;

   cell_cmd_type        cmd;
   entry_type           cell_entry [TASKS];
   logic                cell_after [TASKS];

   logic [ID_W-1:0]     req_task_id;
   logic [TICK_W-1:0]   req_tick_value;
   func_type            req_func;
   logic                out_free, accept, id_ok, list_full, head_due, next_due;

   assign req_task_id    = req_tdata[ID_W-1:0];
   assign req_tick_value = req_tdata[ID_W+TICK_W-1:ID_W];
   assign req_func       = func_type'(req_tuser);

   // Handshake: the result register must be able to take a reply.
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE) && out_free;
   assign accept     = req_tvalid && req_tready;

   assign id_ok     = 32'(req_task_id) < 32'(TASKS);
   assign list_full = cell_entry[TASKS-1].valid;
   assign head_due  = cell_entry[0].valid && (cell_entry[0].deadline <= count_ff);
   assign next_due  = cell_entry[1].valid && (cell_entry[1].deadline <= count_ff);

   // Chain of sorted cells; the head sits at index zero.
   for (genvar i = 0; i < TASKS; i++) begin : g_cell
      entry_type left_e, right_e;
      logic      left_a;
      if (i == 0) begin : g_head
         assign left_e = '0;
         assign left_a = 1'b1;
      end else begin : g_body
         assign left_e = cell_entry[i-1];
         assign left_a = cell_after[i-1];
      end
      if (i == TASKS - 1) begin : g_tail
         assign right_e = '0;
      end else begin : g_inner
         assign right_e = cell_entry[i+1];
      end
      sdrq_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .cmd         (cmd),
         .left_entry  (left_e),
         .left_after  (left_a),
         .right_entry (right_e),
         .entry       (cell_entry[i]),
         .after       (cell_after[i])
      );
   end

   // Controller: decodes requests and drains due tasks after a tick.
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      waiting_in   = waiting_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_kind_in  = rsp_kind_ff;
      rsp_id_in    = rsp_id_ff;
      rsp_time_in  = rsp_time_ff;
      rsp_last_in  = rsp_last_ff;
      cmd.op       = OP_HOLD;
      cmd.task_id  = req_task_id;
      cmd.deadline = (req_func == FUNC_REL) ? count_ff + req_tick_value : req_tick_value;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_func)
                  FUNC_TICK: begin
                     count_in = count_ff + TICK_W'(1);
                     state_in = ST_DRAIN;
                  end
                  FUNC_QUERY: begin
                     rsp_valid_in = 1'b1;
                     rsp_kind_in  = KIND_TIME;
                     rsp_id_in    = '0;
                     rsp_time_in  = count_ff;
                     rsp_last_in  = 1'b1;
                  end
                  default: begin
                     if (id_ok) begin
                        if (waiting_ff[req_task_id]) begin
                           rsp_valid_in = 1'b1;
                           rsp_kind_in  = KIND_REJECT;
                           rsp_id_in    = req_task_id;
                           rsp_time_in  = count_ff;
                           rsp_last_in  = 1'b1;
                        end else if (!list_full) begin
                           cmd.op                  = OP_INSERT;
                           waiting_in[req_task_id] = 1'b1;
                        end
                     end
                  end
               endcase
            end
         end
         ST_DRAIN: begin
            if (!head_due) begin
               state_in = ST_IDLE;
            end else if (out_free) begin
               rsp_valid_in                     = 1'b1;
               rsp_kind_in                      = KIND_RELEASE;
               rsp_id_in                        = cell_entry[0].task_id;
               rsp_time_in                      = count_ff;
               rsp_last_in                      = !next_due;
               cmd.op                           = OP_POP;
               waiting_in[cell_entry[0].task_id] = 1'b0;
               if (!next_due) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         waiting_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         waiting_ff   <= waiting_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_kind_ff <= rsp_kind_in;
      rsp_id_ff   <= rsp_id_in;
      rsp_time_ff <= rsp_time_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = {{(RSP_DATA_W - ID_W - TICK_W){1'b0}}, rsp_time_ff, rsp_id_ff};

endmodule

@@ hdl/sdrq_cell.sv @@
module sdrq_cell
   import sdrq_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  cell_cmd_type cmd,
   input  entry_type    left_entry,
   input  logic         left_after,
   input  entry_type    right_entry,
   output entry_type    entry,
   output logic         after
);

   logic              valid_ff, valid_in;
   logic [TICK_W-1:0] deadline_ff, deadline_in;
   logic [ID_W-1:0]   task_ff, task_in;

   // This slot sorts ahead of the new deadline; equal deadlines go behind the new one.
   assign after = valid_ff && (deadline_ff < cmd.deadline);

   assign entry.valid    = valid_ff;
   assign entry.deadline = deadline_ff;
   assign entry.task_id  = task_ff;

   // Keep, take the new entry, or shift in from a neighbor.
   always_comb begin
      valid_in    = valid_ff;
      deadline_in = deadline_ff;
      task_in     = task_ff;
      case (cmd.op)
         OP_INSERT: begin
            if (!left_after) begin
               valid_in    = left_entry.valid;
               deadline_in = left_entry.deadline;
               task_in     = left_entry.task_id;
            end else if (!after) begin
               valid_in    = 1'b1;
               deadline_in = cmd.deadline;
               task_in     = cmd.task_id;
            end
         end
         OP_POP: begin
            valid_in    = right_entry.valid;
            deadline_in = right_entry.deadline;
            task_in     = right_entry.task_id;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      deadline_ff <= deadline_in;
      task_ff     <= task_in;
   end

endmodule

@@ hdl/sdrq_checker.sv @@
`include "sorted_delay_release_queue_macros.svh"

module sdrq_checker
   import sdrq_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tvalid,
   input logic                  req_tready,
   input logic [FUNC_W-1:0]     req_tuser,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata,
   input logic [1:0]            rsp_tuser,
   input logic                  rsp_tlast
);

   // A stalled result keeps its whole payload.
   `SDRQ_ASSERT_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready,
      rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser) && $stable(rsp_tlast),
      "stalled result changed")

   // Requests are taken only when the result slot can absorb a reply.
   `SDRQ_ASSERT_NOW(a_ready_slot, req_tready, !rsp_tvalid || rsp_tready,
      "request taken while result slot is blocked")

   // A time query is answered in the next cycle as a single final result.
   `SDRQ_ASSERT_NEXT(a_query_reply,
      req_tvalid && req_tready && (req_tuser == FUNC_QUERY),
      rsp_tvalid && (rsp_tuser == KIND_TIME) && rsp_tlast,
      "time query not answered in the next cycle")

   // After a tick transfer the block drains and takes no request at once.
   `SDRQ_ASSERT_NEXT(a_tick_busy,
      req_tvalid && req_tready && (req_tuser == FUNC_TICK), !req_tready,
      "request accepted during tick drain")

endmodule

bind sorted_delay_release_queue sdrq_checker u_sdrq_checker (.*);

@@ tb/sv/tb.sv @@
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import sdrq_pkg::*;

   // Cycles with no transfer on either side before the run is abandoned.
   localparam int unsigned STALL_LIMIT = 2000;
   // Length of the receiver's long hold-off, in cycles.
   localparam int unsigned LONG_HOLD = 300;

   typedef struct {
      kind_type          kind;
      logic [ID_W-1:0]   task_id;
      logic [TICK_W-1:0] time_now;
      logic              last;
   } result_type;

   typedef struct {
      logic [TICK_W-1:0] deadline;
      logic [ID_W-1:0]   task_id;
   } waiter_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;  // task_id [5:0], tick_value [37:6]
   logic [FUNC_W-1:0]     req_tuser = '0;  // func [1:0]
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;       // released_id [5:0], time_now [37:6]
   logic [1:0]            rsp_tuser;       // kind [1:0]
   logic                  rsp_tlast;

   // Predicted state of the block.
   logic [TICK_W-1:0] model_count = '0;
   waiter_type        waiting_list[$];
   bit                task_waiting[ID_SLOTS];

   result_type  expected_results[$];
   int unsigned error_count = 0;

   // Sender and receiver pacing.
   bit          send_calm = 1'b0;
   bit          rsp_busy = 1'b1;
   int unsigned rsp_gap = 0;
   int unsigned hold_requests = 0;
   int unsigned holds_served = 0;
   int unsigned hold_left = 0;
   int unsigned quiet_cycles = 0;

   sorted_delay_release_queue dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   initial forever #6 clock = ~clock;

   // Mostly short gaps, now and then a long one.
   function automatic int unsigned pick_gap();
      if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // Applies one accepted request to the predicted state and queues its results.
   function automatic void predict_request(input func_type func, input logic [ID_W-1:0] id,
                                           input logic [TICK_W-1:0] value);
      waiter_type w;
      int         pos;
      bit         more;
      case (func)
         FUNC_TICK: begin
            model_count = model_count + 1;
            more = waiting_list.size() != 0 && waiting_list[0].deadline <= model_count;
            while (more) begin
               w = waiting_list.pop_front();
               task_waiting[w.task_id] = 1'b0;
               more = waiting_list.size() != 0 && waiting_list[0].deadline <= model_count;
               expected_results.push_back('{KIND_RELEASE, w.task_id, model_count, !more});
            end
         end
         FUNC_QUERY: begin
            expected_results.push_back('{KIND_TIME, '0, model_count, 1'b1});
         end
         default: begin
            if (task_waiting[id]) begin
               expected_results.push_back('{KIND_REJECT, id, model_count, 1'b1});
            end else begin
               w.deadline = (func == FUNC_REL) ? model_count + value : value;
               w.task_id = id;
               // A new entry goes ahead of older ones with the same deadline.
               pos = 0;
               while (pos < waiting_list.size() && waiting_list[pos].deadline < w.deadline)
                  pos++;
               waiting_list.insert(pos, w);
               task_waiting[id] = 1'b1;
            end
         end
      endcase
   endfunction

   // Offers one request and waits for its transfer. Valid stays high afterwards so
   // that back-to-back requests need no second assignment in the same step.
   task automatic offer_request(input func_type func, input logic [ID_W-1:0] id,
                                input logic [TICK_W-1:0] value);
      int unsigned gap;
      gap = 0;
      if ($urandom_range(0, 50) == 0) send_calm = !send_calm;
      if (!send_calm && $urandom_range(0, 2) == 0) gap = pick_gap();
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= func;
      req_tdata <= {2'b00, value, id};
      do @(posedge clock); while (!req_tready);
      predict_request(func, id, value);
   endtask

   // Stops offering and waits until every predicted result has been taken.
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Count at reset, a tick with nothing due, and the count after it.
   task automatic test_tick_and_query();
      offer_request(FUNC_QUERY, '0, '0);
      offer_request(FUNC_TICK, 6'h3f, 32'hffff_ffff);
      offer_request(FUNC_QUERY, 6'h2a, 32'h5555_5555);
   endtask

   // Deadlines already reached are still inserted and leave at the next tick.
   task automatic test_overdue_insert();
      offer_request(FUNC_ABS, 6'd0, 32'd0);
      offer_request(FUNC_REL, 6'd63, 32'hffff_ffff);
      offer_request(FUNC_REL, 6'd1, 32'd0);
      offer_request(FUNC_ABS, 6'd2, model_count);
      offer_request(FUNC_TICK, '0, '0);
   endtask

   // A task that is already waiting is turned away by both delay kinds.
   task automatic test_duplicate_wait();
      offer_request(FUNC_ABS, 6'd7, model_count + 2);
      offer_request(FUNC_REL, 6'd7, 32'd0);
      offer_request(FUNC_ABS, 6'd7, 32'hffff_ffff);
   endtask

   // Equal deadlines leave with the latest insert first.
   task automatic test_tie_order();
      offer_request(FUNC_ABS, 6'd10, model_count + 2);
      offer_request(FUNC_ABS, 6'd11, model_count + 2);
      offer_request(FUNC_ABS, 6'd12, model_count + 2);
      offer_request(FUNC_ABS, 6'd13, model_count + 1);
      offer_request(FUNC_REL, 6'd14, 32'd2);
      offer_request(FUNC_TICK, '0, '0);
      offer_request(FUNC_TICK, '0, '0);
      offer_request(FUNC_QUERY, '0, '0);
   endtask

   // Fills the list with every free task, then releases it all while the
   // receiver holds off and the sender keeps pushing.
   task automatic test_full_list();
      int ids[ID_SLOTS];
      int j;
      int swap;
      wait_drained();
      for (int i = 0; i < ID_SLOTS; i++) ids[i] = i;
      for (int i = ID_SLOTS - 1; i > 0; i--) begin
         j = $urandom_range(0, i);
         swap = ids[i];
         ids[i] = ids[j];
         ids[j] = swap;
      end
      for (int i = 0; i < ID_SLOTS; i++) begin
         if (!task_waiting[ids[i]]) begin
            if ($urandom_range(0, 1) == 0)
               offer_request(FUNC_REL, ids[i][ID_W-1:0], $urandom_range(1, 3));
            else
               offer_request(FUNC_ABS, ids[i][ID_W-1:0], model_count + $urandom_range(1, 3));
         end
      end
      hold_requests <= hold_requests + 1;
      offer_request(FUNC_TICK, '0, '0);
      offer_request(FUNC_QUERY, '0, '0);
      offer_request(FUNC_TICK, '0, '0);
      offer_request(FUNC_QUERY, '0, '0);
      offer_request(FUNC_TICK, '0, '0);
      offer_request(FUNC_QUERY, '0, '0);
      offer_request(FUNC_QUERY, '0, '0);
   endtask

   // Mixed traffic with deadlines mostly close to the count, so that ticks
   // release often; a few far or wrapping deadlines exercise the full width.
   task automatic test_random_traffic(input int unsigned items);
      int unsigned       pick;
      int unsigned       shape;
      logic [ID_W-1:0]   id;
      logic [TICK_W-1:0] value;
      for (int unsigned n = 0; n < items; n++) begin
         if (n == items / 2) hold_requests <= hold_requests + 1;
         pick = $urandom_range(0, 99);
         shape = $urandom_range(0, 19);
         id = ID_W'($urandom_range(0, ID_SLOTS - 1));
         value = $urandom;
         if (pick < 25) begin
            offer_request(FUNC_TICK, id, value);
         end else if (pick < 33) begin
            offer_request(FUNC_QUERY, id, value);
         end else if (pick < 66) begin
            if (shape < 17) value = $urandom_range(0, 6);
            else if (shape == 19) value = 32'hffff_ffff - $urandom_range(0, 15);
            offer_request(FUNC_REL, id, value);
         end else begin
            if (shape < 18)
               value = ((model_count > 3) ? model_count - 3 : '0) + $urandom_range(0, 9);
            offer_request(FUNC_ABS, id, value);
         end
      end
   endtask

   // Receiver: random stalls, quiet stretches, and a long hold-off on request.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_left != 0) begin
         rsp_tready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (hold_requests != holds_served) begin
         rsp_tready <= 1'b0;
         holds_served <= holds_served + 1;
         hold_left <= LONG_HOLD;
      end else if (rsp_gap != 0) begin
         rsp_tready <= 1'b0;
         rsp_gap <= rsp_gap - 1;
      end else begin
         rsp_tready <= 1'b1;
         if (rsp_busy && $urandom_range(0, 3) == 0) rsp_gap <= pick_gap();
      end
      if ($urandom_range(0, 150) == 0) rsp_busy <= !rsp_busy;
   end

   function automatic void check_field(input string field, input logic [TICK_W-1:0] want,
                                       input logic [TICK_W-1:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
         error_count++;
      end
   endfunction

   // Each result transfer is matched against the oldest prediction.
   always @(posedge clock) begin : check_results
      result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_results.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual kind %0d id %0d time %0h",
                     $time, rsp_tuser, rsp_tdata[ID_W-1:0], rsp_tdata[ID_W +: TICK_W]);
            error_count++;
         end else begin
            want = expected_results.pop_front();
            check_field("kind", TICK_W'(want.kind), TICK_W'(rsp_tuser));
            check_field("released_id", TICK_W'(want.task_id), TICK_W'(rsp_tdata[ID_W-1:0]));
            check_field("time_now", want.time_now, rsp_tdata[ID_W +: TICK_W]);
            check_field("last", TICK_W'(want.last), TICK_W'(rsp_tlast));
         end
      end
   end

   // Watchdog on cycles without any transfer.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == STALL_LIMIT) begin
         $display("%0t: no transfer for %0d cycles, %0d results outstanding",
                  $time, STALL_LIMIT, expected_results.size());
         $display("sorted_delay_release_queue test failed");
         $finish;
      end
   end

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      test_tick_and_query();
      test_overdue_insert();
      test_duplicate_wait();
      test_tie_order();
      test_full_list();
      test_random_traffic(370);
      wait_drained();
      if (error_count == 0 && expected_results.size() == 0)
         $display("sorted_delay_release_queue test passed");
      else
         $display("sorted_delay_release_queue test failed");
      $finish;
   end

endmodule

@@ filelist.f @@
+incdir+hdl
hdl/sdrq_pkg.sv
hdl/sdrq_cell.sv
hdl/sorted_delay_release_queue.sv
hdl/sdrq_checker.sv
tb/sv/tb.sv
